// ===== rtl/core/pixel_hsl_colorize_assert.svh =====
// Assertion macros for the pixel HSL colorize block.
// Used by modules that provide clk and rst_n; they expand to nothing for synthesis.
`ifndef PIXEL_HSL_COLORIZE_ASSERT_SVH
`define PIXEL_HSL_COLORIZE_ASSERT_SVH
`ifndef SYNTHESIS
`define PHC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pixel_hsl_colorize: assertion failed");
`define PHC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pixel_hsl_colorize: assertion failed");
`else
`define PHC_ASSERT(lbl, prop)
`define PHC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/core/phc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the HSL colorize pipeline.
// No dependencies.
package phc_pkg;

    localparam logic [6:0]  PCT_MAX   = 7'd100;
    localparam logic [23:0] RECIP100  = 24'd10737419;   // ceil(2^30 / 100)
    localparam logic [7:0]  CHAN_MAX  = 8'hFF;

    localparam logic REG_HUE = 1'b0;
    localparam logic REG_SAT = 1'b1;

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } sector_t;

    typedef struct packed {
        sector_t    sector;
        logic [6:0] weight;
    } hue_cfg_t;

    // floor(n / 100) by reciprocal multiply; exact while the quotient fits 16 bits (n below 6553600)
    function automatic logic [15:0] div100(input logic [22:0] n);
        logic [46:0] p;
        p = {24'd0, n} * {23'd0, RECIP100};
        return p[45:30];
    endfunction

    // Saturate the hue percent and split it into 60-degree sector and triangle weight
    function automatic hue_cfg_t hue_decode(input logic [6:0] pct);
        logic [6:0] h;
        logic [9:0] t;
        logic [9:0] f;
        hue_cfg_t   r;
        h = (pct > PCT_MAX) ? PCT_MAX : pct;
        t = 10'(h) * 10'd6;
        if (t >= 10'd500)
        begin
            r.sector = SEC_MR;
            f = t - 10'd400;
        end
        else if (t >= 10'd400)
        begin
            r.sector = SEC_BM;
            f = t - 10'd400;
        end
        else if (t >= 10'd300)
        begin
            r.sector = SEC_CB;
            f = t - 10'd200;
        end
        else if (t >= 10'd200)
        begin
            r.sector = SEC_GC;
            f = t - 10'd200;
        end
        else if (t >= 10'd100)
        begin
            r.sector = SEC_YG;
            f = t;
        end
        else
        begin
            r.sector = SEC_RY;
            f = t;
        end
        r.weight = (f >= 10'd100) ? 7'(10'd200 - f) : f[6:0];
        return r;
    endfunction

endpackage

// ===== rtl/core/pixel_hsl_colorize.sv =====
// Six stages, three front and three back; each holds one pixel and moves when the next frees.
// Throughput: one pixel per cycle while the output is not stalled.
// A stalled output backs up stage by stage, so bubbles fill before the input stalls.
// Reset clears all stage valid bits; hue and saturation reset to zero (gray output).
// Depends on phc_pkg, phc_cfg, phc_chroma, phc_mix and the assertion header.
`include "pixel_hsl_colorize_assert.svh"
module pixel_hsl_colorize
    import phc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] red_in,
    input  logic [7:0] green_in,
    input  logic [7:0] blue_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] red_out,
    output logic [7:0] green_out,
    output logic [7:0] blue_out
);

    hue_cfg_t    hue;
    logic [6:0]  sat;
    logic        mid_valid;
    logic        mid_ready;
    logic [8:0]  mid_sum;
    logic [15:0] mid_chroma;

    phc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .hue       (hue),
        .sat       (sat)
    );

    phc_chroma u_chroma (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .sat        (sat),
        .out_valid  (mid_valid),
        .out_ready  (mid_ready),
        .out_sum    (mid_sum),
        .out_chroma (mid_chroma)
    );

    phc_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_sum    (mid_sum),
        .in_chroma (mid_chroma),
        .hue       (hue),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

    // a free output lets every stage advance, so the input must be open
    `PHC_ASSERT(a_ready_chain, out_ready |-> in_ready)
    // an internal item blocked by the back half stays put
    `PHC_ASSERT(a_mid_hold, mid_valid && !mid_ready |=> mid_valid && $stable(mid_chroma))
    // chroma is bounded by full scale in 1/255 units
    `PHC_ASSERT(a_chroma_range, mid_valid |-> mid_chroma <= 16'd65280)
    // zero saturation must give zero chroma
    `PHC_ASSERT(a_gray, mid_valid && sat == 7'd0 && $stable(sat) |-> mid_chroma == 16'd0)

endmodule

// ===== rtl/core/phc_cfg.sv =====
// Configuration registers: hue (stored decoded) and saturation (stored saturated).
// Depends on phc_pkg.
module phc_cfg
    import phc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data,
    output hue_cfg_t   hue,
    output logic [6:0] sat
);

    hue_cfg_t   hue_reg;
    hue_cfg_t   hue_next;
    logic [6:0] sat_reg;
    logic [6:0] sat_next;

    always_comb
    begin
        hue_next = hue_reg;
        sat_next = sat_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_HUE: hue_next = hue_decode(cfg_data);
                REG_SAT: sat_next = (cfg_data > PCT_MAX) ? PCT_MAX : cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_reg <= hue_decode(7'd0);
            sat_reg <= 7'd0;
        end
        else
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
        end
    end

    assign hue = hue_reg;
    assign sat = sat_reg;

endmodule

// ===== rtl/core/phc_chroma.sv =====
// Front pipeline, three stages: lightness sum and span, span times saturation,
// divide by 100 to chroma. Depends on phc_pkg.
module phc_chroma
    import phc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic [6:0]  sat,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [8:0]  out_sum,
    output logic [15:0] out_chroma
);

    logic        v1_reg, v2_reg, v3_reg;
    logic        adv1, adv2, adv3;
    logic [8:0]  sum1_reg, sum2_reg, sum3_reg;
    logic [7:0]  span1_reg;
    logic [14:0] n2_reg;
    logic [15:0] chroma3_reg;

    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [8:0]  sum;
    logic [7:0]  span;

    // each stage moves when it is empty or the next one takes its item
    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_comb
    begin
        hi = red_in;
        lo = red_in;
        if (green_in > hi) hi = green_in;
        if (blue_in > hi)  hi = blue_in;
        if (green_in < lo) lo = green_in;
        if (blue_in < lo)  lo = blue_in;
        sum  = {1'b0, hi} + {1'b0, lo};
        span = (sum >= 9'd255) ? 8'(9'd510 - sum) : sum[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            sum1_reg  <= sum;
            span1_reg <= span;
        end
        if (adv2 && v1_reg)
        begin
            sum2_reg <= sum1_reg;
            n2_reg   <= 15'(span1_reg) * 15'(sat);
        end
        if (adv3 && v2_reg)
        begin
            sum3_reg    <= sum2_reg;
            chroma3_reg <= div100({n2_reg, 8'd0});
        end
    end

    assign out_valid  = v3_reg;
    assign out_sum    = sum3_reg;
    assign out_chroma = chroma3_reg;

endmodule

// ===== rtl/core/phc_mix.sv =====
// Back pipeline, three stages: chroma times triangle weight and offset, divide by
// 100 to the second component, sector placement with clamp. Depends on phc_pkg.
module phc_mix
    import phc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [8:0]  in_sum,
    input  logic [15:0] in_chroma,
    input  hue_cfg_t    hue,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out
);

    logic        v4_reg, v5_reg, v6_reg;
    logic        adv4, adv5, adv6;
    logic [22:0] p4_reg;
    logic [15:0] chroma4_reg, chroma5_reg;
    logic [15:0] offs4_reg, offs5_reg;
    logic [15:0] x5_reg;
    logic [7:0]  red6_reg, green6_reg, blue6_reg;

    logic [15:0] c1, c2, c3;

    function automatic logic [7:0] to_chan(input logic [15:0] comp, input logic [15:0] offs);
        logic [16:0] s;
        s = {1'b0, comp} + {1'b0, offs};
        return s[16] ? CHAN_MAX : s[15:8];
    endfunction

    assign adv6     = !v6_reg || out_ready;
    assign adv5     = !v5_reg || adv6;
    assign adv4     = !v4_reg || adv5;
    assign in_ready = adv4;

    always_comb
    begin
        case (hue.sector)
            SEC_RY:
            begin
                c1 = chroma5_reg; c2 = x5_reg;      c3 = 16'd0;
            end
            SEC_YG:
            begin
                c1 = x5_reg;      c2 = chroma5_reg; c3 = 16'd0;
            end
            SEC_GC:
            begin
                c1 = 16'd0;       c2 = chroma5_reg; c3 = x5_reg;
            end
            SEC_CB:
            begin
                c1 = 16'd0;       c2 = x5_reg;      c3 = chroma5_reg;
            end
            SEC_BM:
            begin
                c1 = x5_reg;      c2 = 16'd0;       c3 = chroma5_reg;
            end
            default:
            begin
                c1 = chroma5_reg; c2 = 16'd0;       c3 = x5_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (adv4) v4_reg <= in_valid;
            if (adv5) v5_reg <= v4_reg;
            if (adv6) v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv4 && in_valid)
        begin
            p4_reg      <= 23'(in_chroma) * 23'(hue.weight);
            chroma4_reg <= in_chroma;
            // lightness minus half chroma; chroma never exceeds twice the lightness
            offs4_reg   <= {in_sum, 7'd0} - {1'b0, in_chroma[15:1]};
        end
        if (adv5 && v4_reg)
        begin
            x5_reg      <= div100(p4_reg);
            chroma5_reg <= chroma4_reg;
            offs5_reg   <= offs4_reg;
        end
        if (adv6 && v5_reg)
        begin
            red6_reg   <= to_chan(c1, offs5_reg);
            green6_reg <= to_chan(c2, offs5_reg);
            blue6_reg  <= to_chan(c3, offs5_reg);
        end
    end

    assign out_valid = v6_reg;
    assign red_out   = red6_reg;
    assign green_out = green6_reg;
    assign blue_out  = blue6_reg;

endmodule

// ===== tb/sv/pixel_hsl_colorize_tb.sv =====
// Self-checking testbench for pixel_hsl_colorize: it predicts each colorized pixel and
// compares it against the streamed output under random sender gaps and receiver stalls.
// Depends on phc_pkg and the pixel_hsl_colorize RTL.
`timescale 1ns / 1ps
module pixel_hsl_colorize_tb
    import phc_pkg::*;
();

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write = 1'b0;
    logic       cfg_index = REG_HUE;
    logic [6:0] cfg_data = 7'd0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] red_in = 8'd0;
    logic [7:0] green_in = 8'd0;
    logic [7:0] blue_in = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;

    // shadow copies of the block's registers, raw 7-bit values
    logic [6:0] hue_shadow = 7'd0;
    logic [6:0] sat_shadow = 7'd0;

    pixel_t expected_pixels[$];
    int     pixels_sent = 0;
    int     pixels_checked = 0;
    int     cfg_writes = 0;
    int     fail_count = 0;

    pixel_hsl_colorize i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [7:0] clamp_channel(input logic [31:0] v);
        logic [31:0] q;
        q = v >> 8;
        return (q > 32'd255) ? 8'hFF : q[7:0];
    endfunction

    // Keep the pixel lightness, impose configured hue and saturation.
    // Intermediates are in 1/255 units with 8 fraction bits.
    function automatic pixel_t colorize_predict(input pixel_t px);
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [8:0]  sum;
        logic [6:0]  hue;
        logic [6:0]  sat;
        logic [31:0] lum;
        logic [31:0] span;
        logic [31:0] chroma;
        logic [31:0] xcomp;
        logic [31:0] offs;
        logic [31:0] t;
        logic [31:0] f;
        logic [31:0] weight;
        logic [31:0] c1;
        logic [31:0] c2;
        logic [31:0] c3;
        sector_t     sec;
        pixel_t      res;
        hi = px.red;
        lo = px.red;
        if (px.green > hi) hi = px.green;
        if (px.blue > hi) hi = px.blue;
        if (px.green < lo) lo = px.green;
        if (px.blue < lo) lo = px.blue;
        hue = (hue_shadow > 7'd100) ? 7'd100 : hue_shadow;
        sat = (sat_shadow > 7'd100) ? 7'd100 : sat_shadow;
        sum = 9'(hi) + 9'(lo);
        lum = 32'(sum) * 32'd128;
        span = (sum >= 9'd255) ? 32'd510 - 32'(sum) : 32'(sum);
        chroma = span * 32'd256 * 32'(sat) / 32'd100;
        t = 32'(hue) * 32'd6;
        f = t % 32'd200;
        weight = (f >= 32'd100) ? 32'd200 - f : f;
        xcomp = chroma * weight / 32'd100;
        offs = lum - chroma / 32'd2;
        // hue of exactly 100 percent lands past the last sector; fold it in
        sec = (t >= 32'd500) ? SEC_MR : sector_t'(t / 32'd100);
        case (sec)
            SEC_RY:  begin c1 = chroma; c2 = xcomp;  c3 = 32'd0;  end
            SEC_YG:  begin c1 = xcomp;  c2 = chroma; c3 = 32'd0;  end
            SEC_GC:  begin c1 = 32'd0;  c2 = chroma; c3 = xcomp;  end
            SEC_CB:  begin c1 = 32'd0;  c2 = xcomp;  c3 = chroma; end
            SEC_BM:  begin c1 = xcomp;  c2 = 32'd0;  c3 = chroma; end
            default: begin c1 = chroma; c2 = 32'd0;  c3 = xcomp;  end
        endcase
        res.red   = clamp_channel(c1 + offs);
        res.green = clamp_channel(c2 + offs);
        res.blue  = clamp_channel(c3 + offs);
        return res;
    endfunction

    task automatic check_field(input string fname, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, fname, exp_v, act_v);
            fail_count++;
        end
    endtask

    // result checker: compare each output transfer against the oldest prediction
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t ns: unexpected output pixel %0d %0d %0d",
                         $time, red_out, green_out, blue_out);
                fail_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                check_field("red_out", want.red, red_out);
                check_field("green_out", want.green, green_out);
                check_field("blue_out", want.blue, blue_out);
                pixels_checked++;
            end
        end
    end

    // receiver backpressure: the stall style is redrawn at random as the run goes on
    initial
    begin
        int cyc;
        int stall_left;
        int mode;
        cyc = 0;
        stall_left = 0;
        mode = 0;
        forever
        begin
            @(negedge clk);
            if (cyc % 256 == 0)
                mode = $urandom_range(0, 3);
            cyc++;
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready = 1'b1;
                case (mode)
                    1: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 3);
                    2: if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(5, 24);
                    3: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 8);
                    default: stall_left = 0;
                endcase
            end
        end
    end

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
    endtask

    // present one pixel and hold it until the transfer; valid stays high on return
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        pixel_t px;
        px = {r, g, b};
        @(negedge clk);
        in_valid = 1'b1;
        red_in = r;
        green_in = g;
        blue_in = b;
        do
            @(posedge clk);
        while (!in_ready);
        expected_pixels.push_back(colorize_predict(px));
        pixels_sent++;
    endtask

    // drop valid and hold off until every predicted pixel has come out
    task automatic drain_outputs();
        idle_cycles(1);
        while (expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [6:0] value);
        drain_outputs();
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        if (idx == REG_HUE)
            hue_shadow = value;
        else
            sat_shadow = value;
        cfg_writes++;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(120, 135));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // registers at reset value: output is gray at the input lightness
    task automatic test_gray_after_reset();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd1, 8'd254, 8'd128);
    endtask

    // walk the hue through every sector edge, including above-range values
    task automatic test_hue_sectors();
        logic [6:0] hues[11];
        hues = '{7'd0, 7'd16, 7'd17, 7'd34, 7'd50, 7'd67, 7'd84, 7'd99, 7'd100, 7'd101,
                 7'd127};
        write_cfg(REG_SAT, 7'd100);
        foreach (hues[i])
        begin
            write_cfg(REG_HUE, hues[i]);
            send_pixel(8'd200, 8'd40, 8'd90);
        end
    endtask

    // saturation clamp with peak chroma at mid lightness, the smallest nonzero value, and full saturation
    task automatic test_saturation_limits();
        write_cfg(REG_HUE, 7'd50);
        write_cfg(REG_SAT, 7'd127);
        send_pixel(8'd128, 8'd128, 8'd127);
        write_cfg(REG_SAT, 7'd1);
        send_pixel(8'd10, 8'd250, 8'd100);
        write_cfg(REG_SAT, 7'd100);
        send_pixel(8'd127, 8'd128, 8'd0);
    endtask

    task automatic test_random_stream(input int phases, input int per_phase);
        int burst_left;
        burst_left = 0;
        for (int p = 0; p < phases; p++)
        begin
            case (p)
                0: begin write_cfg(REG_HUE, 7'd0);   write_cfg(REG_SAT, 7'd100); end
                1: begin write_cfg(REG_HUE, 7'd100); write_cfg(REG_SAT, 7'd100); end
                2: begin write_cfg(REG_HUE, 7'd127); write_cfg(REG_SAT, 7'd127); end
                3: begin write_cfg(REG_HUE, 7'd127); write_cfg(REG_SAT, 7'd0);   end
                default:
                begin
                    write_cfg(REG_HUE, 7'($urandom_range(0, 127)));
                    write_cfg(REG_SAT, 7'($urandom_range(0, 127)));
                end
            endcase
            for (int n = 0; n < per_phase; n++)
            begin
                if (p == 2 && n == per_phase / 2)
                    drain_outputs();
                if (burst_left == 0)
                begin
                    idle_cycles($urandom_range(1, 8));
                    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 160)
                                                             : $urandom_range(1, 40);
                end
                send_pixel(pick_channel(), pick_channel(), pick_channel());
                burst_left--;
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_gray_after_reset();
        test_hue_sectors();
        test_saturation_limits();
        test_random_stream(13, 100);

        drain_outputs();
        repeat (16) @(posedge clk);
        $display("Sent %0d pixels over %0d register writes; %0d outputs checked.",
                 pixels_sent, cfg_writes, pixels_checked);
        $display("Covered every hue sector, clamped hue and saturation, and gray output.");
        if (fail_count == 0 && expected_pixels.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d pixels still expected.", expected_pixels.size());
        $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/phc_pkg.sv
rtl/core/phc_cfg.sv
rtl/core/phc_chroma.sv
rtl/core/phc_mix.sv
rtl/core/pixel_hsl_colorize.sv
tb/sv/pixel_hsl_colorize_tb.sv
